/* hdl/line_follow_pid_drive_defines.svh */
// Assertion macros for the line follower drive block.
`ifndef LINE_FOLLOW_PID_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_DRIVE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LFPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define LFPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lfpd_pkg.sv */
// Package: constants and types of the line follower drive block.
`timescale 1ns / 1ps
package lfpd_pkg;

	localparam int SAMPLE_FRAC_BITS_DEF = 12;
	localparam int SUM_WIDTH_DEF        = 24;

	localparam int GAIN_W  = 20;
	localparam int BASE_W  = 10;
	localparam int DRIVE_W = 16;

	localparam logic [GAIN_W-1:0] GAIN_P_RST     = GAIN_W'(61440);
	localparam logic [GAIN_W-1:0] GAIN_D_RST     = GAIN_W'(4096);
	localparam logic [GAIN_W-1:0] GAIN_I_RST     = GAIN_W'(41);
	localparam logic [BASE_W-1:0] BASE_SPEED_RST = BASE_W'(60);

	typedef enum logic [1:0] {
		REG_GAIN_P     = 2'd0,
		REG_GAIN_D     = 2'd1,
		REG_GAIN_I     = 2'd2,
		REG_BASE_SPEED = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		SIDE_NONE  = 2'd0,
		SIDE_LEFT  = 2'd1,
		SIDE_RIGHT = 2'd2
	} side_t;

endpackage

/* hdl/lfpd_sample_if.sv */
// Interface: sensor sample request channel.
`timescale 1ns / 1ps
interface lfpd_sample_if #(
	parameter int SAMPLE_W = lfpd_pkg::SAMPLE_FRAC_BITS_DEF + 1
);
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] middle_sample;
	logic [SAMPLE_W-1:0] right_sample;

	modport source (
		output valid, left_sample, middle_sample, right_sample,
		input  ready
	);
	modport sink (
		input  valid, left_sample, middle_sample, right_sample,
		output ready
	);
endinterface

/* hdl/lfpd_drive_if.sv */
// Interface: wheel drive request channel.
`timescale 1ns / 1ps
interface lfpd_drive_if;
	import lfpd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;

	modport source (
		output valid, left_drive, right_drive,
		input  ready
	);
	modport sink (
		input  valid, left_drive, right_drive,
		output ready
	);
endinterface

/* hdl/line_follow_pid_drive.sv */
// Top level: PID line follower producing differential wheel drive.
// Usage:
//   sensor: request of three darkness samples (Q0.F, 1.0 = 2^F). A set with any
//     sample at 0 or at 1.0 and above is taken and dropped, no drive request.
//   drive:  request of left/right wheel speeds, signed Q12.4 deg/s, saturated.
//   cfg_we/cfg_index/cfg_data: register writes (gain_p, gain_d, gain_i,
//     base_speed); write only while nothing is in flight.
// Path: compare and integral are worked out ahead of the accepting edge and
//   registered in stage 1, then gain products, PID sum, magnitude, x10 scaling,
//   and drive sum with saturation are registered in stages 2 to 6.
// Throughput: one sample set per cycle unless stalled; each stage has its own
//   valid bit and moves up whenever the stage after it is empty or moving.
// Stall: while drive.ready is low the output holds its request, and earlier
//   stages keep filling; sensor.ready drops only when all six stages are full.
// Reset: gains and base speed return to defaults, integral and last error to
//   zero, the next accepted set counts as the first (no derivative/integral),
//   and the pipeline empties.
`timescale 1ns / 1ps
module line_follow_pid_drive #(
	parameter int SAMPLE_FRAC_BITS = lfpd_pkg::SAMPLE_FRAC_BITS_DEF,
	parameter int SUM_WIDTH        = lfpd_pkg::SUM_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lfpd_sample_if.sink                sensor,
	lfpd_drive_if.source               drive,
	input  logic                       cfg_we,
	input  lfpd_pkg::reg_idx_t         cfg_index,
	input  logic [lfpd_pkg::GAIN_W-1:0] cfg_data
);
	import lfpd_pkg::*;

	`include "line_follow_pid_drive_defines.svh"

	localparam int F   = SAMPLE_FRAC_BITS;
	localparam int EW  = F + 2;
	localparam int DW  = EW + 1;
	localparam int XW  = EW + 8;
	localparam int AW  = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
	localparam int LO  = SUM_WIDTH / 2;
	localparam int HI  = SUM_WIDTH - LO;
	localparam int PW  = GAIN_W + ((SUM_WIDTH > DW) ? SUM_WIDTH : DW) + 4;
	localparam int MW  = PW + 4;
	localparam int SH  = F + 8;
	localparam int TW  = 17;
	localparam int RW  = 19;

	localparam logic signed [EW-1:0] TARGET = EW'((36 * (1 << F) + 50) / 100);
	localparam logic signed [XW-1:0] THRESH = XW'(5 * (1 << F));
	localparam logic signed [AW-1:0] SUM_MAX = AW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
	localparam logic signed [AW-1:0] SUM_MIN = ~SUM_MAX;
	localparam logic [TW-1:0]        T_MAX  = TW'(65536);
	localparam logic [MW-1:0]        HALF   = MW'(1) << (SH - 1);

	function automatic logic signed [DRIVE_W-1:0] sat16(input logic signed [RW-1:0] v);
		if (v > RW'(32767)) begin
			return DRIVE_W'(32767);
		end else if (v < -RW'(32768)) begin
			return DRIVE_W'(-32768);
		end
		return v[DRIVE_W-1:0];
	endfunction

	// configuration
	logic [GAIN_W-1:0] gain_p_q, gain_d_q, gain_i_q;
	logic [BASE_W-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_d_q <= GAIN_D_RST;
			gain_i_q <= GAIN_I_RST;
			base_q   <= BASE_SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q <= cfg_data;
				REG_GAIN_D:     gain_d_q <= cfg_data;
				REG_GAIN_I:     gain_i_q <= cfg_data;
				REG_BASE_SPEED: base_q   <= cfg_data[BASE_W-1:0];
				default:        ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || drive.ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign sensor.ready = rdy1;

	// front end: check, error, derivative, integral
	logic                   samples_ok, acc_ok;
	logic signed [EW-1:0]   err;
	logic signed [DW-1:0]   der;
	logic signed [XW-1:0]   err_x;
	logic signed [AW-1:0]   sum_add;
	logic [SUM_WIDTH-1:0]   sum_next;
	side_t                  side;

	logic signed [EW-1:0]   last_error_q;
	logic [SUM_WIDTH-1:0]   error_sum_q;
	logic                   first_q;

	assign samples_ok = (sensor.left_sample != '0)   && !sensor.left_sample[F] &&
	                    (sensor.middle_sample != '0) && !sensor.middle_sample[F] &&
	                    (sensor.right_sample != '0)  && !sensor.right_sample[F];
	assign acc_ok = sensor.valid && rdy1 && samples_ok;

	always_comb begin
		err     = TARGET - $signed(EW'(sensor.middle_sample));
		err_x   = XW'(err) * XW'(100);
		der     = first_q ? '0 : (DW'(last_error_q) - DW'(err));
		sum_add = AW'($signed(error_sum_q)) + AW'(err);
		if (first_q) begin
			sum_next = error_sum_q;
		end else if (sum_add > SUM_MAX) begin
			sum_next = SUM_MAX[SUM_WIDTH-1:0];
		end else if (sum_add < SUM_MIN) begin
			sum_next = SUM_MIN[SUM_WIDTH-1:0];
		end else begin
			sum_next = sum_add[SUM_WIDTH-1:0];
		end
		if (sensor.left_sample > sensor.right_sample) begin
			side = SIDE_LEFT;
		end else if (sensor.left_sample < sensor.right_sample) begin
			side = SIDE_RIGHT;
		end else begin
			side = SIDE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
			first_q      <= 1'b1;
		end else if (acc_ok) begin
			last_error_q <= err;
			error_sum_q  <= sum_next;
			first_q      <= 1'b0;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sensor.valid && samples_ok;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// payload
	logic signed [EW-1:0]           err_s1;
	logic signed [DW-1:0]           der_s1;
	logic [SUM_WIDTH-1:0]           sum_s1;
	side_t                          side_s1, side_s2, side_s3, side_s4, side_s5;
	logic                           gt_s1, gt_s2, gt_s3, gt_s4;

	logic signed [GAIN_W+EW:0]      pp_p_s2;
	logic signed [GAIN_W+DW:0]      pp_d_s2;
	logic [GAIN_W+LO-1:0]           pp_ilo_s2;
	logic signed [GAIN_W+HI:0]      pp_ihi_s2;

	logic signed [PW-1:0]           pid_s3;
	logic [PW-1:0]                  mag_s4;
	logic                           neg_s4, neg_s5;
	logic [TW-1:0]                  tmag_s5;
	logic signed [DRIVE_W-1:0]      left_drive_s6, right_drive_s6;

	logic [MW-1:0]                  scaled;
	logic [MW-SH-1:0]               shifted;
	logic signed [RW-1:0]           t_sg, base_sg, ld, rd;

	always_comb begin
		scaled  = MW'({mag_s4, 3'b000}) + MW'({mag_s4, 1'b0}) + HALF;
		shifted = scaled[MW-1:SH];
		t_sg    = neg_s5 ? -$signed(RW'(tmag_s5)) : $signed(RW'(tmag_s5));
		base_sg = -$signed(RW'({base_q, 4'b0000}));
		unique case (side_s5)
			SIDE_LEFT: begin
				ld = base_sg + t_sg;
				rd = base_sg - t_sg;
			end
			SIDE_RIGHT: begin
				ld = base_sg - t_sg;
				rd = base_sg + t_sg;
			end
			default: begin
				ld = base_sg;
				rd = base_sg;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			err_s1  <= err;
			der_s1  <= der;
			sum_s1  <= sum_next;
			side_s1 <= side;
			gt_s1   <= err_x > THRESH;
		end
		if (rdy2) begin
			pp_p_s2   <= $signed({1'b0, gain_p_q}) * err_s1;
			pp_d_s2   <= $signed({1'b0, gain_d_q}) * der_s1;
			pp_ilo_s2 <= gain_i_q * sum_s1[LO-1:0];
			pp_ihi_s2 <= $signed({1'b0, gain_i_q}) * $signed(sum_s1[SUM_WIDTH-1:LO]);
			side_s2   <= side_s1;
			gt_s2     <= gt_s1;
		end
		if (rdy3) begin
			pid_s3  <= PW'(pp_p_s2) + PW'(pp_d_s2) + (PW'(pp_ihi_s2) <<< LO) +
			           $signed(PW'(pp_ilo_s2));
			side_s3 <= side_s2;
			gt_s3   <= gt_s2;
		end
		if (rdy4) begin
			mag_s4  <= pid_s3[PW-1] ? PW'(-pid_s3) : PW'(pid_s3);
			neg_s4  <= pid_s3[PW-1];
			side_s4 <= side_s3;
			gt_s4   <= gt_s3;
		end
		if (rdy5) begin
			if (!gt_s4) begin
				tmag_s5 <= '0;
			end else if (shifted > (MW-SH)'(T_MAX)) begin
				tmag_s5 <= T_MAX;
			end else begin
				tmag_s5 <= shifted[TW-1:0];
			end
			neg_s5  <= neg_s4;
			side_s5 <= side_s4;
		end
		if (rdy6) begin
			left_drive_s6  <= sat16(ld);
			right_drive_s6 <= sat16(rd);
		end
	end

	assign drive.valid       = v_s6;
	assign drive.left_drive  = left_drive_s6;
	assign drive.right_drive = right_drive_s6;

	// checks
	`LFPD_ASSERT_NXT(a_reject_keeps_state, sensor.valid && rdy1 && !samples_ok,
		$stable(error_sum_q) && $stable(last_error_q) && $stable(first_q),
		"rejected sample set changed PID state")
	`LFPD_ASSERT_IMP(a_first_clears_on_accept, $fell(first_q), $past(acc_ok),
		"first-sample flag cleared without an accepted set")
	`LFPD_ASSERT_IMP(a_backpressure_only_when_full, !sensor.ready,
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6,
		"sensor stalled with an empty stage")

endmodule

/* tb/line_follow_pid_drive_tb.sv */
// Testbench for line_follow_pid_drive: directed table, then random sets against a PID model.
`timescale 1ns / 1ps
module line_follow_pid_drive_tb;
	import lfpd_pkg::*;

	localparam int ONE_LEVEL    = 1 << SAMPLE_FRAC_BITS_DEF;
	localparam int TARGET_LEVEL = (36 * ONE_LEVEL + 50) / 100;
	localparam longint SUM_MAX  = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 1;
	localparam longint SUM_MIN  = -(64'sd1 <<< (SUM_WIDTH_DEF - 1));
	localparam int PID_SHIFT    = 12 + SAMPLE_FRAC_BITS_DEF - 4;
	localparam int DRAIN_CYCLES = 12;
	localparam int QUIET_LIMIT  = 2000;
	localparam int NUM_ROWS     = 28;

	typedef logic [SAMPLE_FRAC_BITS_DEF:0] level_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
	} drive_pair_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_DROP,
		ROW_FIXED,
		ROW_MODEL
	} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		reg_idx_t                  index;
		logic [GAIN_W-1:0]         value;
		level_t                    left;
		level_t                    middle;
		level_t                    right;
		logic signed [DRIVE_W-1:0] exp_left;
		logic signed [DRIVE_W-1:0] exp_right;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	lfpd_sample_if sensor_ch ();
	lfpd_drive_if  drive_ch ();

	line_follow_pid_drive i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sensor    (sensor_ch),
		.drive     (drive_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model copy of registers and loop state
	logic [GAIN_W-1:0] kp = GAIN_P_RST;
	logic [GAIN_W-1:0] kd = GAIN_D_RST;
	logic [GAIN_W-1:0] ki = GAIN_I_RST;
	logic [BASE_W-1:0] base_dps = BASE_SPEED_RST;
	logic signed [SAMPLE_FRAC_BITS_DEF+1:0] prev_err = '0;
	longint err_integral = 0;
	bit first_set = 1'b1;

	drive_pair_t drive_pending[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int pattern_pos = 0;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd100, 13'd1475, 13'd100, -16'sd960, -16'sd960},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd0, 13'd1000, 13'd1000, 16'sd0, 16'sd0},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd1000, 13'd0, 13'd1000, 16'sd0, 16'sd0},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd1000, 13'd1000, 13'd0, 16'sd0, 16'sd0},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd4096, 13'd1000, 13'd1000, 16'sd0, 16'sd0},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd1000, 13'd4096, 13'd1000, 16'sd0, 16'sd0},
		'{ROW_DROP, REG_GAIN_P, 20'd0, 13'd1000, 13'd1000, 13'd8191, 16'sd0, 16'sd0},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd4095, 13'd4095, 13'd4095, -16'sd960, -16'sd960},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd1, 13'd1270, 13'd1, -16'sd960, -16'sd960},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd1, 13'd1271, 13'd4095, -16'sd960, -16'sd960},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd1, 13'd1270, 13'd4095, 16'sd0, 16'sd0},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd4095, 13'd1, 13'd1, 16'sd0, 16'sd0},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd1, 13'd1, 13'd4095, 16'sd0, 16'sd0},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd2048, 13'd600, 13'd1000, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_GAIN_P, 20'd0, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_GAIN_D, 20'd0, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_GAIN_I, 20'd0, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_BASE_SPEED, 20'hFFC00, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd1, 13'd1, 13'd4095, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_BASE_SPEED, 20'd1023, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd4095, 13'd1, 13'd1, -16'sd16368, -16'sd16368},
		'{ROW_CFG, REG_GAIN_P, 20'hFFFFF, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_GAIN_D, 20'hFFFFF, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_CFG, REG_GAIN_I, 20'hFFFFF, 13'd0, 13'd0, 13'd0, 16'sd0, 16'sd0},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd1, 13'd1, 13'd4095, 16'sd0, 16'sd0},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd4095, 13'd1, 13'd1, 16'sd0, 16'sd0},
		'{ROW_FIXED, REG_GAIN_P, 20'd0, 13'd3000, 13'd4095, 13'd1, -16'sd16368, -16'sd16368},
		'{ROW_MODEL, REG_GAIN_P, 20'd0, 13'd5, 13'd300, 13'd7, 16'sd0, 16'sd0}
	};

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic signed [DRIVE_W-1:0] sat_drive(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[DRIVE_W-1:0];
	endfunction

	// one sample set through the loop; returns 0 for a dropped set
	function automatic bit wheel_drive_for(input level_t l, input level_t m, input level_t r,
			output drive_pair_t d);
		longint err, der, pid, base, t, ld, rd;
		longint side_sign;
		longint unsigned mag, scaled;
		d = '0;
		if (l == 0 || l >= ONE_LEVEL || m == 0 || m >= ONE_LEVEL ||
				r == 0 || r >= ONE_LEVEL)
			return 1'b0;
		side_sign = (l > r) ? -1 : ((l < r) ? 1 : 0);
		err = longint'(TARGET_LEVEL) - longint'(m);
		der = 0;
		if (!first_set) begin
			der = longint'(prev_err) - err;
			err_integral = err_integral + err;
			if (err_integral > SUM_MAX)
				err_integral = SUM_MAX;
			if (err_integral < SUM_MIN)
				err_integral = SUM_MIN;
		end
		base = -longint'(base_dps) * 16;
		ld = base;
		rd = base;
		if (err * 100 > 5 * ONE_LEVEL) begin
			pid = longint'(kp) * err + longint'(kd) * der + longint'(ki) * err_integral;
			mag = (pid < 0) ? longint'(-pid) : longint'(pid);
			scaled = (mag * 10 + (64'd1 << (PID_SHIFT - 1))) >> PID_SHIFT;
			if (scaled > 65536)
				scaled = 65536;
			t = (pid < 0) ? -longint'(scaled) : longint'(scaled);
			ld = base - side_sign * t;
			rd = base + side_sign * t;
		end
		d.left_drive = sat_drive(ld);
		d.right_drive = sat_drive(rd);
		prev_err = err;
		first_set = 1'b0;
		return 1'b1;
	endfunction

	function automatic level_t random_level();
		case ($urandom_range(0, 9))
			0: return level_t'(1);
			1: return level_t'(ONE_LEVEL - 1);
			2: return level_t'(ONE_LEVEL / 2);
			default: return level_t'($urandom_range(1, ONE_LEVEL - 1));
		endcase
	endfunction

	function automatic level_t noise_level();
		case ($urandom_range(0, 3))
			0: return level_t'(0);
			1: return level_t'(ONE_LEVEL);
			2: return level_t'(13'h1FFF);
			default: return level_t'($urandom_range(0, 13'h1FFF));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 16'hFFFF));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	task automatic drain_pipeline();
		cfg_we <= 1'b0;
		sensor_ch.valid <= 1'b0;
		burst_left = 0;
		while (drive_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_GAIN_P:     kp = value;
			REG_GAIN_D:     kd = value;
			REG_GAIN_I:     ki = value;
			REG_BASE_SPEED: base_dps = value[BASE_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic program_loop(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] dg,
			input logic [GAIN_W-1:0] ig, input logic [GAIN_W-1:0] base);
		drain_pipeline();
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_D, dg);
		write_reg(REG_GAIN_I, ig);
		write_reg(REG_BASE_SPEED, base);
	endtask

	task automatic send_set(input level_t l, input level_t m, input level_t r,
			input row_kind_t kind, input drive_pair_t typed);
		int gap;
		drive_pair_t d;
		bit got;
		cfg_we <= 1'b0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				sensor_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		sensor_ch.valid <= 1'b1;
		sensor_ch.left_sample <= l;
		sensor_ch.middle_sample <= m;
		sensor_ch.right_sample <= r;
		do
			@(posedge clk);
		while (!sensor_ch.ready);
		burst_left--;
		got = wheel_drive_for(l, m, r, d);
		if (kind == ROW_FIXED)
			drive_pending.push_back(typed);
		else if (kind == ROW_MODEL && got)
			drive_pending.push_back(d);
	endtask

	task automatic send_random_set();
		level_t f [3];
		f[0] = random_level();
		f[1] = ($urandom_range(0, 1) == 0) ? level_t'($urandom_range(1, 1270)) : random_level();
		f[2] = random_level();
		// broken set: one field pushed out of range or to noise
		if ($urandom_range(0, 99) < 12)
			f[$urandom_range(0, 2)] = noise_level();
		send_set(f[0], f[1], f[2], ROW_MODEL, '0);
	endtask

	// receiver: ready follows a rotating pattern, replaced whenever pattern_pos wraps
	always @(posedge clk) begin
		if (pattern_pos == 63) begin
			pattern_pos <= 0;
			ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end else begin
			pattern_pos <= pattern_pos + 1;
		end
		drive_ch.ready <= ready_pattern[pattern_pos % 16];
	end

	always @(posedge clk) begin
		drive_pair_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (drive_pending.size() == 0) begin
				$error("drive request with nothing expected: left %0d right %0d",
					drive_ch.left_drive, drive_ch.right_drive);
				mismatches++;
			end else begin
				want = drive_pending.pop_front();
				if (drive_ch.left_drive !== want.left_drive) begin
					$error("left_drive: expected %0d, got %0d", want.left_drive,
						drive_ch.left_drive);
					mismatches++;
				end
				if (drive_ch.right_drive !== want.right_drive) begin
					$error("right_drive: expected %0d, got %0d", want.right_drive,
						drive_ch.right_drive);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sensor_ch.valid && sensor_ch.ready) || (drive_ch.valid && drive_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAIN_P;
		cfg_data <= '0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.left_sample <= '0;
		sensor_ch.middle_sample <= '0;
		sensor_ch.right_sample <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_pipeline();
				write_reg(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_set(directed_rows[i].left, directed_rows[i].middle,
					directed_rows[i].right, directed_rows[i].kind,
					'{directed_rows[i].exp_left, directed_rows[i].exp_right});
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			program_loop(random_gain(), random_gain(), random_gain(),
				($urandom_range(0, 2) == 0) ? GAIN_W'(ph[0] ? 1023 : 0) : GAIN_W'($urandom));
			repeat (180) send_random_set();
		end

		// integral wind-up with the largest integral gain, then driven back the other way
		program_loop(random_gain(), random_gain(), '1, GAIN_W'($urandom_range(0, 1023)));
		repeat (150)
			send_set(random_level(), level_t'($urandom_range(1, 20)), random_level(),
				ROW_MODEL, '0);
		repeat (150)
			send_set(random_level(), level_t'($urandom_range(4000, ONE_LEVEL - 1)),
				random_level(), ROW_MODEL, '0);
		// recovery with fresh gains
		program_loop(random_gain(), random_gain(), random_gain(), GAIN_W'($urandom));
		repeat (30) send_random_set();

		drain_pipeline();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
